/* design/srt_pkg.sv */
package srt_pkg;

   typedef struct packed {
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] scale_z;
      logic [15:0]        angle_x;
      logic [15:0]        angle_y;
      logic [15:0]        angle_z;
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [31:0] move_z;
   } srt_req_type;

   typedef struct packed {
      logic signed [23:0] m00;
      logic signed [23:0] m01;
      logic signed [23:0] m02;
      logic signed [23:0] m10;
      logic signed [23:0] m11;
      logic signed [23:0] m12;
      logic signed [23:0] m20;
      logic signed [23:0] m21;
      logic signed [23:0] m22;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } srt_rsp_type;

   localparam int CORDIC_STEPS = 30;
   localparam int WORK_BITS    = 30;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // CORDIC rotation state; x and y in Q30 with headroom, z in 2^32 units per turn.
   typedef struct packed {
      logic signed [33:0] x_a, y_a;
      logic signed [33:0] x_b, y_b;
      logic signed [33:0] x_c, y_c;
      logic signed [33:0] z_a, z_b, z_c;
      logic [1:0]         q_a, q_b, q_c;
   } srt_rot_type;

   function automatic logic signed [33:0] atan_turns(input int step);
      logic signed [33:0] v;
      case (step)
         0:  v = 34'sh020000000;  1: v = 34'sh012E4051E;
         2:  v = 34'sh009FB385B;  3: v = 34'sh0051111D4;
         4:  v = 34'sh0028B0D43;  5: v = 34'sh00145D7E1;
         6:  v = 34'sh000A2F61E;  7: v = 34'sh000517C55;
         8:  v = 34'sh00028BE53;  9: v = 34'sh000145F2F;
         10: v = 34'sh0000A2F98; 11: v = 34'sh0000517CC;
         12: v = 34'sh000028BE6; 13: v = 34'sh0000145F3;
         14: v = 34'sh00000A2FA; 15: v = 34'sh00000517D;
         16: v = 34'sh0000028BE; 17: v = 34'sh00000145F;
         18: v = 34'sh000000A30; 19: v = 34'sh000000518;
         20: v = 34'sh00000028C; 21: v = 34'sh000000146;
         22: v = 34'sh0000000A3; 23: v = 34'sh000000051;
         24: v = 34'sh000000029; 25: v = 34'sh000000014;
         26: v = 34'sh00000000A; 27: v = 34'sh000000005;
         28: v = 34'sh000000003; 29: v = 34'sh000000001;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* design/srt_cordic_cell.sv */
module srt_cordic_cell
   import srt_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic        clock,
   input  logic        enable,
   input  srt_rot_type rot_in,
   output srt_rot_type rot_out
);

   srt_rot_type rot_in_w, rot_ff;

   function automatic logic signed [67:0] rotate(
      input logic signed [33:0] x, input logic signed [33:0] y,
      input logic signed [33:0] z);
      logic signed [33:0] dx, dy;
      dx = y >>> STEP;
      dy = x >>> STEP;
      if (!z[33]) begin
         return {x - dx, y + dy};
      end else begin
         return {x + dx, y - dy};
      end
   endfunction

   always_comb begin
      rot_in_w = rot_in;
      {rot_in_w.x_a, rot_in_w.y_a} = rotate(rot_in.x_a, rot_in.y_a, rot_in.z_a);
      {rot_in_w.x_b, rot_in_w.y_b} = rotate(rot_in.x_b, rot_in.y_b, rot_in.z_b);
      {rot_in_w.x_c, rot_in_w.y_c} = rotate(rot_in.x_c, rot_in.y_c, rot_in.z_c);
      rot_in_w.z_a = rot_in.z_a[33] ? rot_in.z_a + atan_turns(STEP)
                                    : rot_in.z_a - atan_turns(STEP);
      rot_in_w.z_b = rot_in.z_b[33] ? rot_in.z_b + atan_turns(STEP)
                                    : rot_in.z_b - atan_turns(STEP);
      rot_in_w.z_c = rot_in.z_c[33] ? rot_in.z_c + atan_turns(STEP)
                                    : rot_in.z_c - atan_turns(STEP);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rot_ff <= rot_in_w;
      end
   end

   assign rot_out = rot_ff;

endmodule

/* design/srt_world_matrix_builder.sv */
// Channel   Direction  Payload        Handshake
// req_      in         srt_req_type   req_valid / req_stall
// rsp_      out        srt_rsp_type   rsp_valid / rsp_stall
//
// One transfer per cycle is accepted while the output is not stalled; the
// pipeline is the 30 CORDIC cells followed by arithmetic and delay stages.
// The whole pipeline advances together and holds when the output register is
// full and stalled; reset is synchronous and clears only the valid bits.
module srt_world_matrix_builder
   import srt_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  srt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output srt_rsp_type rsp_data
);

   localparam int TB = TRIG_FRAC_BITS;
   localparam int TW = TB + 2;
   localparam int PW = 2 * TW;
   localparam int SH = WORK_BITS - TB;
   localparam int SS = TB - 8;
   localparam int SW = TW + 2 + 16;
   localparam int NS = CORDIC_STEPS + 8;

   logic [NS-1:0] vld_ff;
   logic advance;
   assign advance  = !(vld_ff[NS-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NS-2:0], req_valid};
      end
   end

   // Scales and translation travel alongside the datapath.
   srt_req_type side_ff [NS];
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= req_data;
         for (int i = 1; i < NS; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   srt_rot_type chain [CORDIC_STEPS+1];
   srt_rot_type head_w;
   always_comb begin
      head_w.x_a = CORDIC_GAIN; head_w.y_a = '0;
      head_w.x_b = CORDIC_GAIN; head_w.y_b = '0;
      head_w.x_c = CORDIC_GAIN; head_w.y_c = '0;
      head_w.z_a = {4'b0, req_data.angle_x[13:0], 16'b0};
      head_w.z_b = {4'b0, req_data.angle_y[13:0], 16'b0};
      head_w.z_c = {4'b0, req_data.angle_z[13:0], 16'b0};
      head_w.q_a = req_data.angle_x[15:14];
      head_w.q_b = req_data.angle_y[15:14];
      head_w.q_c = req_data.angle_z[15:14];
   end
   assign chain[0] = head_w;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      srt_cordic_cell #(.STEP(g)) u_cell (
         .clock(clock), .enable(advance), .rot_in(chain[g]), .rot_out(chain[g+1])
      );
   end

   function automatic logic signed [TW-1:0] to_trig(input logic signed [33:0] v);
      logic signed [33:0] r, one;
      r   = (v + (34'sd1 <<< (SH - 1))) >>> SH;
      one = 34'sd1 <<< TB;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[TW-1:0];
   endfunction

   function automatic logic signed [PW-1:0] qmul(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b);
      return (p + (PW'(1) <<< (TB - 1))) >>> TB;
   endfunction

   function automatic logic signed [23:0] sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = (SS == 0) ? v : ((v + (SW'(1) <<< (SS - 1))) >>> SS);
      if (r > SW'(8388607)) return 24'sh7FFFFF;
      if (r < -SW'(8388608)) return 24'sh800000;
      return r[23:0];
   endfunction

   // Stage 1: round, clamp and quadrant-map the sine and cosine.
   logic signed [TW-1:0] ca_ff, sa_ff, cb_ff, sb_ff, cg_ff, sg_ff;
   logic signed [TW-1:0] c_w [3], s_w [3];
   logic [1:0] q_w [3];
   logic signed [33:0] xr_w [3], yr_w [3];
   logic signed [TW-1:0] co_w [3], si_w [3];
   srt_rot_type last;
   assign last = chain[CORDIC_STEPS];

   always_comb begin
      xr_w[0] = last.x_a; yr_w[0] = last.y_a; q_w[0] = last.q_a;
      xr_w[1] = last.x_b; yr_w[1] = last.y_b; q_w[1] = last.q_b;
      xr_w[2] = last.x_c; yr_w[2] = last.y_c; q_w[2] = last.q_c;
      for (int k = 0; k < 3; k++) begin
         c_w[k] = to_trig(xr_w[k]);
         s_w[k] = to_trig(yr_w[k]);
         case (q_w[k])
            2'd0:    begin co_w[k] = c_w[k];  si_w[k] = s_w[k];  end
            2'd1:    begin co_w[k] = -s_w[k]; si_w[k] = c_w[k];  end
            2'd2:    begin co_w[k] = -c_w[k]; si_w[k] = -s_w[k]; end
            default: begin co_w[k] = s_w[k];  si_w[k] = -c_w[k]; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ca_ff <= co_w[0]; sa_ff <= si_w[0];
         cb_ff <= co_w[1]; sb_ff <= si_w[1];
         cg_ff <= co_w[2]; sg_ff <= si_w[2];
      end
   end

   // Stage 2: first products.
   logic signed [TW-1:0] ca2_ff, sa2_ff, sb2_ff;
   logic signed [TW-1:0] cgsb_ff, sgsb_ff, cgcb_ff, sgca_ff, sgsa_ff, sgcb_ff,
                         cgca_ff, cgsa_ff, cbsa_ff, cbca_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         ca2_ff <= ca_ff; sa2_ff <= sa_ff; sb2_ff <= sb_ff;
         cgsb_ff <= TW'(qmul(cg_ff, sb_ff));
         sgsb_ff <= TW'(qmul(sg_ff, sb_ff));
         cgcb_ff <= TW'(qmul(cg_ff, cb_ff));
         sgca_ff <= TW'(qmul(sg_ff, ca_ff));
         sgsa_ff <= TW'(qmul(sg_ff, sa_ff));
         sgcb_ff <= TW'(qmul(sg_ff, cb_ff));
         cgca_ff <= TW'(qmul(cg_ff, ca_ff));
         cgsa_ff <= TW'(qmul(cg_ff, sa_ff));
         cbsa_ff <= TW'(qmul(cb_ff, sa_ff));
         cbca_ff <= TW'(qmul(cb_ff, ca_ff));
      end
   end

   // Stage 3: second-level products and sums.
   logic signed [TW+1:0] e_ff [9];
   always_ff @(posedge clock) begin
      if (advance) begin
         e_ff[0] <= (TW+2)'(cgcb_ff);
         e_ff[1] <= (TW+2)'(sgca_ff) + (TW+2)'(TW'(qmul(cgsb_ff, sa2_ff)));
         e_ff[2] <= (TW+2)'(sgsa_ff) - (TW+2)'(TW'(qmul(cgsb_ff, ca2_ff)));
         e_ff[3] <= -(TW+2)'(sgcb_ff);
         e_ff[4] <= (TW+2)'(cgca_ff) - (TW+2)'(TW'(qmul(sgsb_ff, sa2_ff)));
         e_ff[5] <= (TW+2)'(cgsa_ff) + (TW+2)'(TW'(qmul(sgsb_ff, ca2_ff)));
         e_ff[6] <= (TW+2)'(sb2_ff);
         e_ff[7] <= -(TW+2)'(cbsa_ff);
         e_ff[8] <= (TW+2)'(cbca_ff);
      end
   end

   // Stage 4: scale, stage 5: round and saturate.
   srt_req_type sd;
   assign sd = side_ff[CORDIC_STEPS + 2];
   logic signed [SW-1:0] p_ff [9];
   logic signed [15:0] k_w [9];
   always_comb begin
      for (int j = 0; j < 9; j++) begin
         k_w[j] = (j < 3) ? sd.scale_x : ((j < 6) ? sd.scale_y : sd.scale_z);
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 9; j++) p_ff[j] <= SW'(k_w[j]) * SW'(e_ff[j]);
      end
   end

   logic signed [23:0] m_ff [9];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 9; j++) m_ff[j] <= sat(p_ff[j]);
      end
   end

   // Remaining stages only delay, so the latency matches the side line.
   logic signed [23:0] d_ff [NS-CORDIC_STEPS-5][9];
   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff[0] <= m_ff;
         for (int i = 1; i < NS - CORDIC_STEPS - 5; i++) d_ff[i] <= d_ff[i-1];
      end
   end

   logic signed [23:0] mo [9];
   assign mo = d_ff[NS-CORDIC_STEPS-6];
   srt_req_type so;
   assign so = side_ff[NS-1];
   always_comb begin
      rsp_data.m00 = mo[0]; rsp_data.m01 = mo[1]; rsp_data.m02 = mo[2];
      rsp_data.m10 = mo[3]; rsp_data.m11 = mo[4]; rsp_data.m12 = mo[5];
      rsp_data.m20 = mo[6]; rsp_data.m21 = mo[7]; rsp_data.m22 = mo[8];
      rsp_data.out_x = so.move_x;
      rsp_data.out_y = so.move_y;
      rsp_data.out_z = so.move_z;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");
   a_lat: assert property (@(posedge clock) disable iff (reset)
      !req_stall && !req_valid && !vld_ff[NS-2] |=> !rsp_valid || $past(rsp_stall))
      else $error("result appeared without an item");

endmodule

/* dv/tb.sv */
module tb
   import srt_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     FRAC       = 16;
   localparam int     RAND_ITEMS = 1030;
   localparam int     LIMIT      = 400000;
   localparam int     DRAIN      = 60;
   localparam longint ELEM_HI    = 8388607;
   localparam longint ELEM_LO    = -8388608;

   typedef enum logic [1:0] {QUAD0, QUAD1, QUAD2, QUAD3} quad_type;

   localparam longint ATAN_TURNS [30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
   };

   typedef struct {
      srt_req_type req;
      bit          typed;
      srt_rsp_type want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   srt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   srt_rsp_type rsp_data;

   srt_rsp_type matrix_q[$];
   int          errors = 0;
   int          cycles = 0;
   int          matrices_seen = 0;
   bit          calm = 1'b0;
   int          stall_left = 0;

   srt_world_matrix_builder #(.TRIG_FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // Half-up rounding: add half an LSB, then floor.
   function automatic longint round_half_up(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint unit_clamp(input longint v);
      longint one;
      one = 64'sd1 <<< FRAC;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
   endfunction

   function automatic void sin_cos(input logic [15:0] ang, output longint co,
                                   output longint si);
      longint x, y, z, dx, dy, c, s;
      x = 652032874;
      y = 0;
      z = longint'(ang[13:0]) <<< 16;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - ATAN_TURNS[i];
         end else begin
            x = x + dx; y = y - dy; z = z + ATAN_TURNS[i];
         end
      end
      c = unit_clamp(round_half_up(x, 30 - FRAC));
      s = unit_clamp(round_half_up(y, 30 - FRAC));
      case (quad_type'(ang[15:14]))
         QUAD0: begin co = c;  si = s;  end
         QUAD1: begin co = -s; si = c;  end
         QUAD2: begin co = -c; si = -s; end
         default: begin co = s; si = -c; end
      endcase
   endfunction

   function automatic longint tmul(input longint a, input longint b);
      return round_half_up(a * b, FRAC);
   endfunction

   function automatic logic [23:0] scaled(input logic signed [15:0] k, input longint v);
      longint r;
      r = round_half_up(longint'(k) * v, FRAC - 8);
      if (r > ELEM_HI) r = ELEM_HI;
      if (r < ELEM_LO) r = ELEM_LO;
      return r[23:0];
   endfunction

   function automatic srt_rsp_type build_matrix(input srt_req_type r);
      srt_rsp_type m;
      longint ca, sa, cb, sb, cg, sg;
      sin_cos(r.angle_x, ca, sa);
      sin_cos(r.angle_y, cb, sb);
      sin_cos(r.angle_z, cg, sg);
      m.m00 = scaled(r.scale_x, tmul(cg, cb));
      m.m01 = scaled(r.scale_x, tmul(sg, ca) + tmul(tmul(cg, sb), sa));
      m.m02 = scaled(r.scale_x, tmul(sg, sa) - tmul(tmul(cg, sb), ca));
      m.m10 = scaled(r.scale_y, -tmul(sg, cb));
      m.m11 = scaled(r.scale_y, tmul(cg, ca) - tmul(tmul(sg, sb), sa));
      m.m12 = scaled(r.scale_y, tmul(cg, sa) + tmul(tmul(sg, sb), ca));
      m.m20 = scaled(r.scale_z, sb);
      m.m21 = scaled(r.scale_z, -tmul(cb, sa));
      m.m22 = scaled(r.scale_z, tmul(cb, ca));
      m.out_x = r.move_x;
      m.out_y = r.move_y;
      m.out_z = r.move_z;
      return m;
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   function automatic logic [15:0] pick_angle();
      logic [15:0] marks [10] = '{16'h0000, 16'h0001, 16'h3FFF, 16'h4000,
                                  16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000,
                                  16'hFFFF, 16'h2000};
      if ($urandom_range(0, 4) == 0) return marks[$urandom_range(0, 9)];
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] pick_scale();
      logic [15:0] marks [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0100,
                                 16'hFF00, 16'h0001};
      case ($urandom_range(0, 7))
         0: return marks[$urandom_range(0, 5)];
         1, 2, 3: return 16'($urandom_range(0, 65535));
         default: return 16'($signed($urandom_range(0, 4096)) - 2048);
      endcase
   endfunction

   function automatic srt_req_type random_req();
      srt_req_type r;
      r.scale_x = pick_scale();
      r.scale_y = pick_scale();
      r.scale_z = pick_scale();
      r.angle_x = pick_angle();
      r.angle_y = pick_angle();
      r.angle_z = pick_angle();
      r.move_x  = $urandom();
      r.move_y  = $urandom();
      r.move_z  = $urandom();
      return r;
   endfunction

   function automatic row_type make_row(input logic [15:0] k, input logic [15:0] ax,
                                        input logic [15:0] ay, input logic [15:0] az,
                                        input logic [31:0] mv);
      row_type t;
      t.req = '{k, k, k, ax, ay, az, mv, ~mv, mv ^ 32'h5A5A_A5A5};
      // A zero scale clears every element; the translation always passes through.
      t.typed = (k == 16'h0000);
      t.want = '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
                 mv, ~mv, mv ^ 32'h5A5A_A5A5};
      return t;
   endfunction

   task automatic send(input srt_req_type r, input srt_rsp_type want);
      req_valid = 1'b1;
      req_data  = r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      matrix_q.push_back(want);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic idle_gap();
      if (!calm && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 17)) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (matrix_q.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (calm || reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 6) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      srt_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         matrices_seen++;
         if (matrix_q.size() == 0) begin
            $error("matrix transfer with no expectation pending");
            errors++;
         end else begin
            want = matrix_q.pop_front();
            check_field("m00", want.m00, rsp_data.m00);
            check_field("m01", want.m01, rsp_data.m01);
            check_field("m02", want.m02, rsp_data.m02);
            check_field("m10", want.m10, rsp_data.m10);
            check_field("m11", want.m11, rsp_data.m11);
            check_field("m12", want.m12, rsp_data.m12);
            check_field("m20", want.m20, rsp_data.m20);
            check_field("m21", want.m21, rsp_data.m21);
            check_field("m22", want.m22, rsp_data.m22);
            check_field("out_x", want.out_x, rsp_data.out_x);
            check_field("out_y", want.out_y, rsp_data.out_y);
            check_field("out_z", want.out_z, rsp_data.out_z);
         end
      end
   end

   initial begin
      row_type     rows [$];
      srt_req_type r;
      int          guard;
      rows.push_back(make_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000));
      rows.push_back(make_row(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      rows.push_back(make_row(16'h0000, 16'h4000, 16'h8000, 16'hC000, 32'h8000_0000));
      rows.push_back(make_row(16'h0000, 16'h1234, 16'hABCD, 16'h7FFF, 32'h7FFF_FFFF));
      rows.push_back(make_row(16'h0100, 16'h0000, 16'h0000, 16'h0000, 32'h0001_0000));
      rows.push_back(make_row(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 32'h1234_5678));
      rows.push_back(make_row(16'h8000, 16'h0000, 16'h0000, 16'h0000, 32'h8765_4321));
      rows.push_back(make_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'hDEAD_BEEF));
      rows.push_back(make_row(16'h7FFF, 16'h2000, 16'h2000, 16'h2000, 32'h0F0F_0F0F));
      rows.push_back(make_row(16'h0100, 16'h4000, 16'h0000, 16'h0000, 32'h0000_0001));
      rows.push_back(make_row(16'h0100, 16'h0000, 16'h4000, 16'h0000, 32'h0000_0002));
      rows.push_back(make_row(16'h0100, 16'h0000, 16'h0000, 16'h4000, 32'h0000_0003));
      rows.push_back(make_row(16'h0100, 16'hC000, 16'h8000, 16'h3FFF, 32'hFFFF_0000));
      rows.push_back(make_row(16'hFF00, 16'h0001, 16'hFFFF, 16'hBFFF, 32'h5555_AAAA));
      rows.push_back(make_row(16'h0001, 16'h1555, 16'h2AAA, 16'h6000, 32'hAAAA_5555));
      rows.push_back(make_row(16'h4000, 16'h2000, 16'hE000, 16'hA000, 32'h0000_FFFF));
      rows.push_back(make_row(16'hC000, 16'h6000, 16'h9FFF, 16'h0800, 32'hFFFF_FFFE));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         send(rows[i].req, rows[i].typed ? rows[i].want : build_matrix(rows[i].req));
         idle_gap();
      end

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS / 2) wait_drained();
         if (n == RAND_ITEMS - 150) calm = 1'b1;
         r = random_req();
         send(r, build_matrix(r));
         idle_gap();
      end

      wait_drained();
      guard = 0;
      while (guard < DRAIN) begin
         @(negedge clock);
         guard++;
      end

      $display("Sent %0d transforms (%0d directed), checked %0d matrices in %0d cycles.",
               rows.size() + RAND_ITEMS, rows.size(), matrices_seen, cycles);
      $display("Covered scale and angle extremes, quadrant edges and saturation.");
      if (errors == 0 && matrix_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
